>>> sv/gpad_pkg.sv
// ----------------------------------------------------------------------------
// gpad_pkg
// Shared types, constants and tables for the gamepad edge and auto-repeat block.
// ----------------------------------------------------------------------------
package gpad_pkg;

    // field widths
    localparam int BTN_W    = 16;
    localparam int AXIS_W   = 8;
    localparam int COUNT_W  = 32;
    localparam int DIR_W    = 4;
    localparam int HELD_W   = 16;
    localparam int THR_W    = 7;
    localparam int DELAY_W  = 8;
    localparam int CFG_W    = 16;
    localparam int CFG_A_W  = 2;

    // stream widths
    localparam int IN_DATA_W  = 128;
    localparam int OUT_DATA_W = 120;

    // frames between auto-repeat pulses once the delay has passed (1..64)
    localparam int REPEAT_INTERVAL = 5;
    localparam int PHASE_W = (REPEAT_INTERVAL > 1) ? $clog2(REPEAT_INTERVAL) : 1;

    // register reset values
    localparam logic [BTN_W-1:0]   MASK_RST  = 16'hFFFF;
    localparam logic [THR_W-1:0]   THR_RST   = 7'd50;
    localparam logic [DELAY_W-1:0] DELAY_RST = 8'd15;
    localparam logic [HELD_W-1:0]  HELD_MAX  = 16'hFFFF;

    // configuration register indexes
    typedef enum logic [CFG_A_W-1:0] {
        CFG_BUTTON_MASK     = 2'd0,
        CFG_STICK_THRESHOLD = 2'd1,
        CFG_REPEAT_DELAY    = 2'd2
    } cfg_idx_t;

    // direction bit positions
    localparam int DIR_UP    = 0;
    localparam int DIR_DOWN  = 1;
    localparam int DIR_LEFT  = 2;
    localparam int DIR_RIGHT = 3;

    typedef logic [PHASE_W-1:0] phase_t;
    typedef phase_t phase_tab_t [256];

    // input transaction, first field in the lowest bits
    typedef struct packed {
        logic signed [COUNT_W-1:0] frame_divider;
        logic signed [COUNT_W-1:0] last_post_count;
        logic signed [COUNT_W-1:0] vi_count;
        logic signed [AXIS_W-1:0]  axis_y;
        logic signed [AXIS_W-1:0]  axis_x;
        logic [BTN_W-1:0]          raw_buttons;
    } in_item_t;

    // output transaction, first field in the lowest bits
    typedef struct packed {
        logic [6:0]               pad;
        logic [HELD_W-1:0]        held_frames;
        logic                     repeat_pulse;
        logic [DIR_W-1:0]         dir_released;
        logic [DIR_W-1:0]         dir_pressed;
        logic [DIR_W-1:0]         dir_before;
        logic [BTN_W-1:0]         buttons_released;
        logic [BTN_W-1:0]         buttons_pressed;
        logic [BTN_W-1:0]         buttons_before;
        logic [DIR_W-1:0]         dir_now;
        logic signed [AXIS_W-1:0] stick_y_out;
        logic signed [AXIS_W-1:0] stick_x_out;
        logic [BTN_W-1:0]         buttons_now;
    } out_item_t;

    // value mod REPEAT_INTERVAL for every 8-bit delay, built by counting
    function automatic phase_tab_t build_phase_tab();
        phase_tab_t tab;
        int         r;
        r = 0;
        for (int i = 0; i < 256; i++)
        begin
            tab[i] = phase_t'(r);
            r = (r == REPEAT_INTERVAL - 1) ? 0 : r + 1;
        end
        return tab;
    endfunction

    localparam phase_tab_t DELAY_PHASE = build_phase_tab();

endpackage

>>> sv/gamepad_edge_and_autorepeat.sv
// ----------------------------------------------------------------------------
// gamepad_edge_and_autorepeat
// Pad sample edge detection, game-frame publishing and auto-repeat.
// ----------------------------------------------------------------------------
// One pad sample in, one result out, at a sustained rate of one transaction
// per clock while the result side is not stalled. A sample sits in an input
// register; the mask, stick threshold, boundary compare and held-counter
// logic run combinationally from there, and the result lands in an output
// register, which raises output valid when it loads the result. The input
// side stays ready while a result waits downstream as long as the input
// register can hand over. Edges are gathered on every sample and published
// only on game-frame boundaries (the first sample after reset is always
// one). Configuration writes take effect on the next sample and should be
// made while the block is idle.
// ----------------------------------------------------------------------------
module gamepad_edge_and_autorepeat
    import gpad_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_A_W-1:0]     cfg_addr,
    input  logic [CFG_W-1:0]       cfg_wdata,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // raw_buttons, axis_x, axis_y, vi_count, last_post_count, frame_divider
    input  logic [IN_DATA_W-1:0]   s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // buttons_now, stick_x_out, stick_y_out, dir_now, buttons_before,
    // buttons_pressed, buttons_released, dir_before, dir_pressed,
    // dir_released, repeat_pulse, held_frames, zero pad
    output logic [OUT_DATA_W-1:0]  m_axis_tdata
);

    // configuration
    logic [BTN_W-1:0]   mask_reg;
    logic [THR_W-1:0]   thr_reg;
    logic [DELAY_W-1:0] delay_reg;

    // pipeline
    logic      in_valid_reg;
    in_item_t  in_reg;
    logic      out_valid_reg;
    out_item_t out_reg;
    out_item_t out_next;
    logic      advance;

    // block state
    logic               have_base_reg;
    logic [BTN_W-1:0]   host_btn_reg;
    logic [DIR_W-1:0]   host_dir_reg;
    logic [BTN_W-1:0]   btn_rise_reg;
    logic [BTN_W-1:0]   btn_fall_reg;
    logic [DIR_W-1:0]   dir_rise_reg;
    logic [DIR_W-1:0]   dir_fall_reg;
    logic [BTN_W-1:0]   frame_btn_reg;
    logic [DIR_W-1:0]   frame_dir_reg;
    logic [HELD_W-1:0]  held_reg;
    phase_t             phase_reg;

    logic [BTN_W-1:0]   btn;
    logic [DIR_W-1:0]   dir;
    logic [BTN_W-1:0]   btn_rise_next;
    logic [BTN_W-1:0]   btn_fall_next;
    logic [DIR_W-1:0]   dir_rise_next;
    logic [DIR_W-1:0]   dir_fall_next;
    logic [HELD_W-1:0]  held_next;
    phase_t             phase_next;
    logic               boundary;
    logic               held_same;
    logic               fire;

    logic signed [AXIS_W:0]    sx;
    logic signed [AXIS_W:0]    sy;
    logic signed [AXIS_W:0]    thr_pos;
    logic signed [AXIS_W:0]    thr_neg;
    logic signed [COUNT_W+1:0] span;
    logic signed [COUNT_W+1:0] div_eff;

    assign advance       = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mask_reg  <= MASK_RST;
            thr_reg   <= THR_RST;
            delay_reg <= DELAY_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_addr)
                CFG_BUTTON_MASK:     mask_reg  <= cfg_wdata[BTN_W-1:0];
                CFG_STICK_THRESHOLD: thr_reg   <= cfg_wdata[THR_W-1:0];
                CFG_REPEAT_DELAY:    delay_reg <= cfg_wdata[DELAY_W-1:0];
                default: ;
            endcase
        end
    end

    // input register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
        begin
            in_reg <= in_item_t'(s_axis_tdata);
        end
    end

    // sample processing
    always_comb
    begin
        btn     = in_reg.raw_buttons & mask_reg;
        sx      = {in_reg.axis_x[AXIS_W-1], in_reg.axis_x};
        sy      = {in_reg.axis_y[AXIS_W-1], in_reg.axis_y};
        thr_pos = $signed({2'b00, thr_reg});
        thr_neg = -thr_pos;

        dir = '0;
        if (sx < thr_neg)
        begin
            dir[DIR_LEFT] = 1'b1;
        end
        else if (sx > thr_pos)
        begin
            dir[DIR_RIGHT] = 1'b1;
        end
        if (sy < thr_neg)
        begin
            dir[DIR_DOWN] = 1'b1;
        end
        else if (sy > thr_pos)
        begin
            dir[DIR_UP] = 1'b1;
        end

        btn_rise_next = btn_rise_reg | (btn & ~host_btn_reg);
        btn_fall_next = btn_fall_reg | (host_btn_reg & ~btn);
        dir_rise_next = dir_rise_reg | (dir & ~host_dir_reg);
        dir_fall_next = dir_fall_reg | (host_dir_reg & ~dir);

        // exact retrace span, two guard bits so nothing wraps
        span = {{2{in_reg.vi_count[COUNT_W-1]}}, in_reg.vi_count}
             + (COUNT_W+2)'(1)
             - {{2{in_reg.last_post_count[COUNT_W-1]}}, in_reg.last_post_count};
        if (in_reg.frame_divider <= 0)
        begin
            div_eff = (COUNT_W+2)'(1);
        end
        else
        begin
            div_eff = {{2{in_reg.frame_divider[COUNT_W-1]}}, in_reg.frame_divider};
        end
        boundary = !have_base_reg || (span >= div_eff);

        held_same = ((btn != '0) || (dir != '0))
                 && (frame_btn_reg == btn) && (frame_dir_reg == dir);

        // phase tracks held count mod the repeat interval
        held_next  = held_reg;
        phase_next = phase_reg;
        fire       = 1'b0;
        if (held_same)
        begin
            if (held_reg != HELD_MAX)
            begin
                held_next  = held_reg + 1'b1;
                phase_next = (phase_reg == phase_t'(REPEAT_INTERVAL - 1)) ?
                             '0 : phase_reg + 1'b1;
            end
            fire = (held_next >= {{(HELD_W-DELAY_W){1'b0}}, delay_reg})
                && (phase_next == DELAY_PHASE[delay_reg]);
        end
        else
        begin
            held_next  = '0;
            phase_next = '0;
        end

        out_next             = out_reg;
        out_next.pad         = '0;
        out_next.buttons_now = btn;
        out_next.stick_x_out = in_reg.axis_x;
        out_next.stick_y_out = in_reg.axis_y;
        out_next.dir_now     = dir;
        if (boundary)
        begin
            out_next.buttons_before   = frame_btn_reg;
            out_next.buttons_pressed  = btn_rise_next;
            out_next.buttons_released = btn_fall_next;
            out_next.dir_before       = frame_dir_reg;
            out_next.dir_pressed      = dir_rise_next;
            out_next.dir_released     = dir_fall_next;
            out_next.repeat_pulse     = fire;
            out_next.held_frames      = held_next;
        end
    end

    // state and output register; published fields live in the output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
            have_base_reg <= 1'b0;
            host_btn_reg  <= '0;
            host_dir_reg  <= '0;
            btn_rise_reg  <= '0;
            btn_fall_reg  <= '0;
            dir_rise_reg  <= '0;
            dir_fall_reg  <= '0;
            frame_btn_reg <= '0;
            frame_dir_reg <= '0;
            held_reg      <= '0;
            phase_reg     <= '0;
        end
        else
        begin
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (advance)
            begin
                out_reg      <= out_next;
                host_btn_reg <= btn;
                host_dir_reg <= dir;
                if (boundary)
                begin
                    have_base_reg <= 1'b1;
                    frame_btn_reg <= btn;
                    frame_dir_reg <= dir;
                    held_reg      <= held_next;
                    phase_reg     <= phase_next;
                    btn_rise_reg  <= '0;
                    btn_fall_reg  <= '0;
                    dir_rise_reg  <= '0;
                    dir_fall_reg  <= '0;
                end
                else
                begin
                    btn_rise_reg <= btn_rise_next;
                    btn_fall_reg <= btn_fall_next;
                    dir_rise_reg <= dir_rise_next;
                    dir_fall_reg <= dir_fall_next;
                end
            end
        end
    end

endmodule

>>> sv/gpad_checker.sv
// ----------------------------------------------------------------------------
// gpad_checker
// Port-level checks for the gamepad edge and auto-repeat block.
// ----------------------------------------------------------------------------
module gpad_checker
    import gpad_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  s_axis_tready,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata
);

    out_item_t res;
    assign res = out_item_t'(m_axis_tdata);

    // a stalled result transaction holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // with nothing waiting at the output the input side must be open
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input blocked with empty output");

    // opposite directions never show together
    a_dir_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> !(res.dir_now[DIR_UP] && res.dir_now[DIR_DOWN])
                       && !(res.dir_now[DIR_LEFT] && res.dir_now[DIR_RIGHT]))
        else $error("opposite directions both set");

    // a repeat pulse only comes with a held input
    a_repeat_held: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && res.repeat_pulse |-> res.held_frames != '0)
        else $error("repeat pulse with zero held count");

endmodule

bind gamepad_edge_and_autorepeat gpad_checker u_gpad_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

>>> verif/gamepad_edge_and_autorepeat_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gamepad_edge_and_autorepeat_tb
// Self-checking stream testbench for the pad edge and auto-repeat block.
// ----------------------------------------------------------------------------
// Pad samples go in on the slave stream with random bursts and gaps, and the
// master stream is drained with its own changing stall pattern. Every accepted
// sample runs through a cycle-free model of the masking, stick thresholds,
// edge gathering, game-frame publishing and held counter; each result
// transaction is compared field by field with the oldest prediction. A
// directed opening hits the threshold, count and divider corner cases; random
// phases under different register settings then hold inputs across game
// frames so that auto-repeat fires, and a short final run goes back to the
// reset register values with a fixed repeat delay.
// ----------------------------------------------------------------------------
module gamepad_edge_and_autorepeat_tb;
    import gpad_pkg::*;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_A_W-1:0]    cfg_addr;
    logic [CFG_W-1:0]      cfg_wdata;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    // raw_buttons, axis_x, axis_y, vi_count, last_post_count, frame_divider
    logic [IN_DATA_W-1:0]  s_axis_tdata;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    // buttons_now, stick_x_out, stick_y_out, dir_now, buttons_before,
    // buttons_pressed, buttons_released, dir_before, dir_pressed,
    // dir_released, repeat_pulse, held_frames, zero pad
    logic [OUT_DATA_W-1:0] m_axis_tdata;

    class pad_report_model;
        logic [BTN_W-1:0]   mask;
        logic [THR_W-1:0]   thr;
        logic [DELAY_W-1:0] delay;
        bit                 have_baseline;
        logic [BTN_W-1:0]   host_btn;
        logic [DIR_W-1:0]   host_dir;
        logic [BTN_W-1:0]   btn_rise;
        logic [BTN_W-1:0]   btn_fall;
        logic [DIR_W-1:0]   dir_rise;
        logic [DIR_W-1:0]   dir_fall;
        logic [BTN_W-1:0]   frame_btn;
        logic [DIR_W-1:0]   frame_dir;
        logic [HELD_W-1:0]  held;
        out_item_t          published;
        out_item_t          pending_reports[$];
        int                 mismatches;
        int                 reported;

        function new();
            mask          = MASK_RST;
            thr           = THR_RST;
            delay         = DELAY_RST;
            have_baseline = 1'b0;
            host_btn      = '0;
            host_dir      = '0;
            btn_rise      = '0;
            btn_fall      = '0;
            dir_rise      = '0;
            dir_fall      = '0;
            frame_btn     = '0;
            frame_dir     = '0;
            held          = '0;
            published     = '0;
            mismatches    = 0;
            reported      = 0;
        endfunction

        function void write_reg(cfg_idx_t idx, logic [CFG_W-1:0] value);
            case (idx)
                CFG_BUTTON_MASK:     mask  = value[BTN_W-1:0];
                CFG_STICK_THRESHOLD: thr   = value[THR_W-1:0];
                CFG_REPEAT_DELAY:    delay = value[DELAY_W-1:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return pending_reports.size();
        endfunction

        function void take_sample(in_item_t s);
            out_item_t        r;
            logic [BTN_W-1:0] b;
            logic [DIR_W-1:0] d;
            int               sx;
            int               sy;
            int               t;
            longint           span;
            longint           div;
            b  = s.raw_buttons & mask;
            sx = $signed(s.axis_x);
            sy = $signed(s.axis_y);
            t  = int'(thr);
            d  = '0;
            if (sx < -t)
                d[DIR_LEFT] = 1'b1;
            else if (sx > t)
                d[DIR_RIGHT] = 1'b1;
            if (sy < -t)
                d[DIR_DOWN] = 1'b1;
            else if (sy > t)
                d[DIR_UP] = 1'b1;

            btn_rise |= b & ~host_btn;
            btn_fall |= host_btn & ~b;
            dir_rise |= d & ~host_dir;
            dir_fall |= host_dir & ~d;
            host_btn = b;
            host_dir = d;

            // exact span, no 32-bit wrap
            span = longint'($signed(s.vi_count)) + 1 - longint'($signed(s.last_post_count));
            div  = longint'($signed(s.frame_divider));
            if (div <= 0)
                div = 1;

            if (!have_baseline || span >= div)
            begin
                have_baseline              = 1'b1;
                published.buttons_before   = frame_btn;
                published.buttons_pressed  = btn_rise;
                published.buttons_released = btn_fall;
                published.dir_before       = frame_dir;
                published.dir_pressed      = dir_rise;
                published.dir_released     = dir_fall;
                published.repeat_pulse     = 1'b0;
                if ((b != '0 || d != '0) && frame_btn == b && frame_dir == d)
                begin
                    if (held != HELD_MAX)
                        held++;
                    if (held >= delay &&
                        ((int'(held) - int'(delay)) % REPEAT_INTERVAL) == 0)
                        published.repeat_pulse = 1'b1;
                end
                else
                    held = '0;
                frame_btn = b;
                frame_dir = d;
                btn_rise  = '0;
                btn_fall  = '0;
                dir_rise  = '0;
                dir_fall  = '0;
            end

            r             = published;
            r.pad         = '0;
            r.buttons_now = b;
            r.stick_x_out = s.axis_x;
            r.stick_y_out = s.axis_y;
            r.dir_now     = d;
            r.held_frames = held;
            pending_reports.push_back(r);
        endfunction

        function void note_fail(string name, logic [BTN_W-1:0] want, logic [BTN_W-1:0] got);
            mismatches++;
            if (reported < 40)
            begin
                reported++;
                $error("%s: expected 0x%0h, actual 0x%0h", name, want, got);
            end
        endfunction

        function void cmp(string name, logic [BTN_W-1:0] want, logic [BTN_W-1:0] got);
            if (want !== got)
                note_fail(name, want, got);
        endfunction

        function void check_report(out_item_t got);
            out_item_t want;
            if (pending_reports.size() == 0)
            begin
                note_fail("unexpected transaction", '0, got.buttons_now);
                return;
            end
            want = pending_reports.pop_front();
            cmp("buttons_now", want.buttons_now, got.buttons_now);
            cmp("stick_x_out", $unsigned(want.stick_x_out), $unsigned(got.stick_x_out));
            cmp("stick_y_out", $unsigned(want.stick_y_out), $unsigned(got.stick_y_out));
            cmp("dir_now", want.dir_now, got.dir_now);
            cmp("buttons_before", want.buttons_before, got.buttons_before);
            cmp("buttons_pressed", want.buttons_pressed, got.buttons_pressed);
            cmp("buttons_released", want.buttons_released, got.buttons_released);
            cmp("dir_before", want.dir_before, got.dir_before);
            cmp("dir_pressed", want.dir_pressed, got.dir_pressed);
            cmp("dir_released", want.dir_released, got.dir_released);
            cmp("repeat_pulse", want.repeat_pulse, got.repeat_pulse);
            cmp("held_frames", want.held_frames, got.held_frames);
        endfunction
    endclass

    pad_report_model reports = new();

    // sender and scheduler state
    int                      burst_left;
    logic signed [COUNT_W-1:0] vi_ctr;
    logic signed [COUNT_W-1:0] post_ctr;
    logic signed [COUNT_W-1:0] div_cur;

    gamepad_edge_and_autorepeat i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #10ms;
        $display("gamepad_edge_and_autorepeat regression: fail");
        $finish;
    end

    task automatic send_sample(logic [BTN_W-1:0] btn, logic signed [AXIS_W-1:0] x,
                               logic signed [AXIS_W-1:0] y, logic signed [COUNT_W-1:0] vi,
                               logic signed [COUNT_W-1:0] last,
                               logic signed [COUNT_W-1:0] dv);
        in_item_t s;
        int       gap;
        s.raw_buttons     = btn;
        s.axis_x          = x;
        s.axis_y          = y;
        s.vi_count        = vi;
        s.last_post_count = last;
        s.frame_divider   = dv;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= s;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        reports.take_sample(s);
        burst_left--;
    endtask

    task automatic send_noise();
        send_sample(BTN_W'($urandom), AXIS_W'($urandom), AXIS_W'($urandom),
                    $urandom, $urandom, $urandom);
    endtask

    // host frames up to and including the next game-frame boundary
    task automatic game_frame(logic [BTN_W-1:0] btn, logic signed [AXIS_W-1:0] x,
                              logic signed [AXIS_W-1:0] y, int jitter_pct);
        bit     bnd;
        longint span;
        longint dv;
        do
        begin
            dv   = (div_cur <= 0) ? 1 : longint'(div_cur);
            span = longint'(vi_ctr) + 1 - longint'(post_ctr);
            bnd  = (span >= dv);
            if (bnd || $urandom_range(0, 99) >= jitter_pct)
                send_sample(btn, x, y, vi_ctr, post_ctr, div_cur);
            else
                send_sample(BTN_W'($urandom), AXIS_W'($urandom), AXIS_W'($urandom),
                            vi_ctr, post_ctr, div_cur);
            if (bnd)
                post_ctr = vi_ctr + 1;
            vi_ctr = vi_ctr + 1;
        end
        while (!bnd);
    endtask

    function automatic logic signed [AXIS_W-1:0] pick_axis();
        int t;
        t = int'(reports.thr);
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return AXIS_W'(t);
            2:       return AXIS_W'((t < 127) ? t + 1 : 127);
            3:       return AXIS_W'(-t);
            4:       return AXIS_W'(-t - 1);
            5:       return 8'sh80;
            6:       return 8'sh7F;
            default: return AXIS_W'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [BTN_W-1:0] pick_buttons();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return 16'h0001 << $urandom_range(0, BTN_W - 1);
            2:       return BTN_W'($urandom);
            default: return 16'hFFFF;
        endcase
    endfunction

    // held inputs across game frames with random content, plus noise
    task automatic run_holds(int budget);
        int                       sent;
        int                       frames;
        int                       jitter;
        int                       cap;
        bit                       first;
        logic [BTN_W-1:0]         b;
        logic signed [AXIS_W-1:0] x;
        logic signed [AXIS_W-1:0] y;
        sent  = 0;
        first = 1'b1;
        while (sent < budget)
        begin
            if (!first && $urandom_range(0, 4) == 0)
            begin
                send_noise();
                sent++;
            end
            else
            begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4, 5: div_cur = 1;
                    6, 7:             div_cur = 2;
                    8:                div_cur = 3;
                    default:          div_cur = -$urandom_range(0, 5);
                endcase
                b      = pick_buttons();
                x      = pick_axis();
                y      = pick_axis();
                jitter = $urandom_range(0, 1) ? 0 : 30;
                if (first)
                begin
                    // long enough for the held count to reach this delay
                    div_cur = 1;
                    b       = b | 16'h0001;
                    x       = 8'sh80;
                    frames  = int'(reports.delay) + $urandom_range(1, 12);
                end
                else
                begin
                    cap    = int'(reports.delay) + 12;
                    frames = $urandom_range(1, (cap < 45) ? cap : 45);
                end
                repeat (frames)
                begin
                    game_frame(b, x, y, jitter);
                    sent += (div_cur > 1) ? int'(div_cur) : 1;
                end
                first = 1'b0;
            end
        end
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [CFG_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= value;
        reports.write_reg(idx, value);
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // drain everything in flight before touching the registers
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        while (reports.pending() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // receiver with a stall pattern that changes mode every so often
    initial
    begin
        int mode;
        int mode_left;
        int stall_left;
        int tick;
        mode          = 0;
        mode_left     = 0;
        stall_left    = 0;
        tick          = 0;
        m_axis_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (m_axis_tvalid && m_axis_tready)
                reports.check_report(m_axis_tdata);
            if (mode_left == 0)
            begin
                mode      = $urandom_range(0, 3);
                mode_left = $urandom_range(20, 200);
            end
            mode_left--;
            tick++;
            case (mode)
                0: m_axis_tready <= 1'b1;
                1: m_axis_tready <= 1'($urandom_range(0, 1));
                2: m_axis_tready <= (tick % 3 == 0);
                default:
                begin
                    if (stall_left > 0)
                    begin
                        stall_left--;
                        m_axis_tready <= 1'b0;
                    end
                    else if ($urandom_range(0, 15) == 0)
                    begin
                        stall_left = $urandom_range(0, 7);
                        m_axis_tready <= 1'b0;
                    end
                    else
                        m_axis_tready <= 1'b1;
                end
            endcase
        end
    end

    initial
    begin
        logic [BTN_W-1:0] hi;
        rst_n         <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_addr      <= CFG_BUTTON_MASK;
        cfg_wdata     <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        burst_left = 0;
        vi_ctr     = 0;
        post_ctr   = 0;
        div_cur    = 1;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // first sample is a boundary even though the counts say otherwise
        send_sample(16'h0001, 8'sd0, 8'sd0, 10, 0, 100);
        // edges gathered between boundaries, stick extremes and threshold edges
        send_sample(16'hFFFF, 8'sh80, 8'sh7F, 10, 0, 100);
        send_sample(16'h0000, 8'sh7F, 8'sh80, 10, 0, 100);
        send_sample(16'h8000, 8'sd50, -8'sd50, 10, 0, 100);
        // span of 2^32 must not wrap
        send_sample(16'h8000, 8'sd51, -8'sd51, 32'sh7FFFFFFF, 32'sh80000000, 32'sh7FFFFFFF);
        send_sample(16'h8000, -8'sd51, 8'sd51, 32'sh80000000, 32'sh7FFFFFFF, 1);
        // zero and negative dividers count as one
        send_sample(16'h5A5A, -8'sd50, 8'sd50, 5, 5, 0);
        send_sample(16'hA5A5, 8'sd0, 8'sd0, 5, 6, 32'sh80000000);
        send_sample(16'hA5A5, 8'sd0, 8'sd0, 5, 5, -1);
        // idle input never counts as held
        send_sample(16'h0000, 8'sd0, 8'sd0, 0, 0, 1);
        send_sample(16'h0000, 8'sd0, 8'sd0, 0, 0, 1);
        // span exactly at the divider and one short of it
        send_sample(16'h0000, 8'sd0, 8'sd0, 9, 7, 3);
        send_sample(16'h0000, 8'sd0, 8'sd0, 8, 7, 3);
        // direction-only hold
        repeat (4) send_sample(16'h0000, 8'sh80, 8'sd0, 1, 1, 1);

        for (int p = 0; p < 8; p++)
        begin
            settle();
            hi = BTN_W'($urandom);
            case (p)
                0:
                begin
                    write_reg(CFG_BUTTON_MASK, 16'hFFFF);
                    write_reg(CFG_STICK_THRESHOLD, 16'd0);
                    write_reg(CFG_REPEAT_DELAY, 16'd1);
                end
                1:
                begin
                    write_reg(CFG_BUTTON_MASK, 16'h0000);
                    write_reg(CFG_STICK_THRESHOLD, 16'd127);
                    write_reg(CFG_REPEAT_DELAY, 16'd255);
                end
                2:
                begin
                    write_reg(CFG_BUTTON_MASK, CFG_W'($urandom));
                    write_reg(CFG_STICK_THRESHOLD, {hi[15:7], 7'($urandom)});
                    write_reg(CFG_REPEAT_DELAY, {hi[15:8], 8'd0});
                end
                default:
                begin
                    write_reg(CFG_BUTTON_MASK, pick_buttons() | 16'h0001);
                    write_reg(CFG_STICK_THRESHOLD, {hi[15:7], 7'($urandom)});
                    write_reg(CFG_REPEAT_DELAY, {hi[15:8], 8'($urandom_range(1, 40))});
                end
            endcase
            vi_ctr   = $urandom_range(0, 2000000) - 1000000;
            post_ctr = vi_ctr;
            run_holds(30);
        end

        // back to the reset settings with a fixed repeat delay
        settle();
        write_reg(CFG_BUTTON_MASK, MASK_RST);
        write_reg(CFG_STICK_THRESHOLD, CFG_W'(THR_RST));
        write_reg(CFG_REPEAT_DELAY, 16'd20);
        div_cur = 1;
        run_holds(20);

        settle();
        repeat (8) @(posedge clk);
        if (reports.mismatches == 0)
            $display("gamepad_edge_and_autorepeat regression: pass");
        else
            $display("gamepad_edge_and_autorepeat regression: fail");
        $finish;
    end

endmodule
